[rtl/icrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icrc_pkg
// Shared constants, register indexes and the byte-wise CRC-32 update used by
// the image CRC checker.
// ----------------------------------------------------------------------------
package icrc_pkg;

    localparam int unsigned ADDR_BITS_DEF = 24;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = 32;
    localparam int unsigned CRC_W         = 32;
    localparam int unsigned BYTE_W        = 8;

    localparam logic [CRC_W-1:0] CRC_SEED = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_IMAGE_BYTES    = 2'd0;
    localparam t_cfg_idx REG_EXPECTED_CRC   = 2'd1;
    localparam t_cfg_idx REG_DEBUG_SUPPRESS = 2'd2;

    // Reflected CRC-32 over one byte, LSB first. Equivalent to the usual
    // 256-entry table whose entry 1 is 0x77073096.
    function automatic logic [CRC_W-1:0] crc32_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int b = 0; b < BYTE_W; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/icrc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icrc interfaces
// Valid/ready channels of the image CRC checker: image bytes in, pass
// results out, and configuration register writes.
// ----------------------------------------------------------------------------
interface icrc_byte_if;
    logic                        valid;
    logic                        ready;
    logic [icrc_pkg::BYTE_W-1:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

interface icrc_result_if;
    logic                       valid;
    logic                       ready;
    logic [icrc_pkg::CRC_W-1:0] final_crc;
    logic                       crc_match;
    logic                       fault;

    modport source (output valid, output final_crc, output crc_match, output fault,
                    input ready);
    modport sink   (input valid, input final_crc, input crc_match, input fault,
                    output ready);
endinterface

interface icrc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [icrc_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [icrc_pkg::CFG_DATA_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

[rtl/image_crc32_checker_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_crc32_checker_top
// Streaming reflected CRC-32 check of a code image against a stored value.
// ----------------------------------------------------------------------------
//  Port           Dir  Carries
//  i_byte         in   one image byte per transaction (code_byte)
//  o_result       out  final_crc, crc_match, fault at the end of each pass
//  i_cfg          in   register writes: image_bytes, expected_crc,
//                      debug_suppress
//
//  One byte is taken every cycle unless the input stalls; the byte-wise
//  CRC update is combinational. A result appears in the cycle after the
//  last byte of a pass. Reset is synchronous and active low. The input
//  stalls only while a finished result is held in the output register
//  and the sink is not ready. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module image_crc32_checker_top #(
    parameter int unsigned ADDR_BITS = icrc_pkg::ADDR_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    icrc_byte_if.sink    i_byte,
    icrc_result_if.source o_result,
    icrc_cfg_if.sink     i_cfg
);
    import icrc_pkg::*;

    logic [ADDR_BITS-1:0] r_image_bytes, n_image_bytes;
    logic [CRC_W-1:0]     r_expected_crc, n_expected_crc;
    logic                 r_debug_suppress, n_debug_suppress;
    logic [CRC_W-1:0]     r_crc, n_crc;
    logic [ADDR_BITS-1:0] r_remain, n_remain;
    logic                 r_out_valid, n_out_valid;
    logic [CRC_W-1:0]     r_final_crc, n_final_crc;
    logic                 r_match, n_match;
    logic                 r_fault, n_fault;

    logic                 byte_acc;
    logic                 cfg_acc;
    logic                 last_byte;
    logic [CRC_W-1:0]     crc_upd;

    assign i_cfg.ready  = 1'b1;
    assign cfg_acc      = i_cfg.valid;
    assign i_byte.ready = !r_out_valid || o_result.ready;
    assign byte_acc     = i_byte.valid && i_byte.ready;

    assign crc_upd   = crc32_byte(r_crc, i_byte.code_byte);
    // A count of zero behaves like one: every byte closes a pass.
    assign last_byte = !(r_remain > ADDR_BITS'(1));

    always_comb begin
        n_image_bytes    = r_image_bytes;
        n_expected_crc   = r_expected_crc;
        n_debug_suppress = r_debug_suppress;
        n_crc            = r_crc;
        n_remain         = r_remain;
        n_out_valid      = r_out_valid;
        n_final_crc      = r_final_crc;
        n_match          = r_match;
        n_fault          = r_fault;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        if (byte_acc) begin
            if (last_byte) begin
                n_out_valid = 1'b1;
                n_final_crc = crc_upd;
                n_match     = (crc_upd == r_expected_crc);
                n_fault     = (crc_upd != r_expected_crc) && !r_debug_suppress;
                n_crc       = CRC_SEED;
                n_remain    = r_image_bytes;
            end else begin
                n_crc    = crc_upd;
                n_remain = r_remain - ADDR_BITS'(1);
            end
        end

        // Writing the length restarts the pass with the new count.
        if (cfg_acc) begin
            case (i_cfg.reg_index)
                REG_IMAGE_BYTES: begin
                    n_image_bytes = i_cfg.wr_data[ADDR_BITS-1:0];
                    n_crc         = CRC_SEED;
                    n_remain      = i_cfg.wr_data[ADDR_BITS-1:0];
                end
                REG_EXPECTED_CRC: begin
                    n_expected_crc = i_cfg.wr_data[CRC_W-1:0];
                end
                REG_DEBUG_SUPPRESS: begin
                    n_debug_suppress = i_cfg.wr_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_bytes    <= ADDR_BITS'(1);
            r_expected_crc   <= '0;
            r_debug_suppress <= 1'b0;
            r_crc            <= CRC_SEED;
            r_remain         <= ADDR_BITS'(1);
            r_out_valid      <= 1'b0;
        end else begin
            r_image_bytes    <= n_image_bytes;
            r_expected_crc   <= n_expected_crc;
            r_debug_suppress <= n_debug_suppress;
            r_crc            <= n_crc;
            r_remain         <= n_remain;
            r_out_valid      <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_final_crc <= n_final_crc;
        r_match     <= n_match;
        r_fault     <= n_fault;
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.final_crc = r_final_crc;
    assign o_result.crc_match = r_match;
    assign o_result.fault     = r_fault;

endmodule
